>>> rtl/core/rat_pkg.sv
// Shared types and constants for the repeating alarm table.
// Used by the controller, the datapath and the top level.
`default_nettype none
package rat_pkg;

  localparam int TimeW = 40;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam int StepW = 20;
  localparam logic [StepW-1:0] DaySeconds  = 20'd86400;
  localparam logic [StepW-1:0] WeekSeconds = 20'd604800;

  // Reciprocals floor(2^40 / interval) for the remainder unit.
  localparam int RecW = 24;
  localparam logic [RecW-1:0] DayRecip  = 24'd12725829;
  localparam logic [RecW-1:0] WeekRecip = 24'd1817975;

  // Action codes.
  localparam logic [1:0] ActClear   = 2'd0;
  localparam logic [1:0] ActWrite   = 2'd1;
  localparam logic [1:0] ActService = 2'd2;

  // Repeat codes.
  localparam logic [1:0] RepOnce   = 2'd0;
  localparam logic [1:0] RepDaily  = 2'd1;
  localparam logic [1:0] RepWeekly = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic apply;
    logic scan_start;
    logic div_start;
    logic div_step;
    logic emit_fire;
    logic upd;
    logic idx_inc;
    logic emit_sum;
  } rat_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;
    logic once;
    logic div_done;
    logic last_idx;
    logic out_free;
  } rat_status_t;

  // Repeat interval in seconds; zero for a once entry.
  function automatic logic [StepW-1:0] interval_of(input logic [1:0] rep);
    logic [StepW-1:0] s;
    s = '0;
    if (rep == RepDaily) s = DaySeconds;
    else if (rep == RepWeekly) s = WeekSeconds;
    return s;
  endfunction

  // Reciprocal of the repeat interval; zero for a once entry.
  function automatic logic [RecW-1:0] recip_of(input logic [1:0] rep);
    logic [RecW-1:0] m;
    m = '0;
    if (rep == RepDaily) m = DayRecip;
    else if (rep == RepWeekly) m = WeekRecip;
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rat_ram.sv
// Generic single write port RAM with a registered read port.
// No dependencies.
`default_nettype none
module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/rat_ctrl.sv
// Controller state machine of the alarm table: sequences apply, scan,
// fire reports, remainder iterations and the summary. Uses rat_pkg.
`default_nettype none
module rat_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rat_pkg::rat_status_t sts,
  output rat_pkg::rat_cmd_t         cmd
);
  import rat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_RD, S_CHK, S_EMIT, S_DIV, S_UPD, S_SUM
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.hit) begin
          cmd.div_start = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_fire = 1'b1;
          state_nxt = sts.once ? S_UPD : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_UPD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.last_idx) begin
          state_nxt = S_SUM;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rat_dp.sv
// Datapath of the alarm table: slot RAM, valid bits, reciprocal-multiply
// remainder unit, earliest-due tracking and the output register. Uses rat_pkg, rat_ram.
`default_nettype none
module rat_dp #(
  parameter int SLOTS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rat_pkg::rat_cmd_t         cmd,
  output rat_pkg::rat_status_t           sts,
  input  wire logic [1:0]                in_action,
  input  wire logic [3:0]                in_slot,
  input  wire logic                      in_is_timer,
  input  wire logic [1:0]                in_repeat_mode,
  input  wire logic [rat_pkg::TimeW-1:0] in_due_time,
  input  wire logic [rat_pkg::TimeW-1:0] in_now_time,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_kind,
  output logic [3:0]                     out_fired_slot,
  output logic                           out_fired_is_timer,
  output logic [1:0]                     out_fired_repeat,
  output logic [rat_pkg::TimeW-1:0]      out_fired_due,
  output logic [rat_pkg::TimeW-1:0]      out_next_due,
  output logic [4:0]                     out_fired_count,
  output logic                           out_last
);
  import rat_pkg::*;

  localparam int AW = $clog2(SLOTS > 1 ? SLOTS : 2);
  localparam int RW = TimeW + 3;
  localparam int HalfW = TimeW / 2;
  localparam int MulW = HalfW + RecW;
  localparam int AccW = MulW + 1;

  // Latched input item.
  logic [1:0]       act_r;
  logic [3:0]       slot_r;
  logic             tmr_r;
  logic [1:0]       rep_r;
  logic [TimeW-1:0] due_r;
  logic [TimeW-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= in_action;
      slot_r <= in_slot;
      tmr_r  <= in_is_timer;
      rep_r  <= (in_repeat_mode == 2'd3) ? RepOnce : in_repeat_mode;
      due_r  <= in_due_time;
      now_r  <= in_now_time;
    end
  end

  // Slot storage.
  logic [AW-1:0]    idx_r;
  logic [SLOTS-1:0] valid_r;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;
  logic             wr_ok;

  assign wr_ok = (act_r == ActWrite) && (32'(slot_r) < 32'(SLOTS));

  rat_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Current entry fields.
  logic             cur_v;
  logic             cur_tmr;
  logic [1:0]       cur_rep;
  logic [TimeW-1:0] cur_due;
  logic [StepW-1:0] cur_step;
  logic [RecW-1:0]  cur_recip;

  assign cur_v     = valid_r[idx_r];
  assign cur_tmr   = ram_rdata[RW-1];
  assign cur_rep   = ram_rdata[RW-2:RW-3];
  assign cur_due   = ram_rdata[TimeW-1:0];
  assign cur_step  = interval_of(cur_rep);
  assign cur_recip = recip_of(cur_rep);

  // Remainder of (now - due) by the interval in four steps: the quotient
  // estimate floor(diff * recip / 2^40) from two half products, the low
  // bits of quotient times interval, then one correcting subtraction.
  logic [TimeW-1:0]   diff_r;
  logic [AccW-1:0]    acc_r;
  logic [StepW:0]     qs_r;
  logic [StepW-1:0]   rem_r;
  logic [2:0]         dcnt_r;
  logic [HalfW-1:0]   mul_a;
  logic [MulW-1:0]    mul_p;
  logic [2*StepW:0]   qs_p;
  logic [StepW:0]     rem_raw;
  logic [StepW:0]     rem_cor;

  assign mul_a   = (dcnt_r == 3'd4) ? diff_r[HalfW-1:0] : diff_r[TimeW-1:HalfW];
  assign mul_p   = {{RecW{1'b0}}, mul_a} * {{HalfW{1'b0}}, cur_recip};
  assign qs_p    = {{StepW{1'b0}}, acc_r[HalfW+StepW:HalfW]}
                 * {{(StepW+1){1'b0}}, cur_step};
  assign rem_raw = diff_r[StepW:0] - qs_r;
  assign rem_cor = rem_raw - {1'b0, cur_step};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      diff_r <= now_r - cur_due;
      dcnt_r <= 3'd4;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 3'd1;
      case (dcnt_r)
        3'd4: acc_r <= {1'b0, mul_p};
        3'd3: acc_r <= {1'b0, mul_p} + {{HalfW{1'b0}}, acc_r[AccW-1:HalfW]};
        3'd2: qs_r  <= qs_p[StepW:0];
        3'd1: rem_r <= (rem_raw >= {1'b0, cur_step}) ? rem_cor[StepW-1:0]
                                                     : rem_raw[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Advanced due time: now - rem + step, saturated.
  logic [TimeW:0]   adv_sum;
  logic [TimeW-1:0] adv_due;

  assign adv_sum = {1'b0, now_r} - {{(TimeW + 1 - StepW){1'b0}}, rem_r}
                 + {{(TimeW + 1 - StepW){1'b0}}, cur_step};
  assign adv_due = adv_sum[TimeW] ? TimeMax : adv_sum[TimeW-1:0];

  // Hit test and final state of the current slot.
  logic             hit;
  logic             once;
  logic             fin_ok;
  logic [TimeW-1:0] fin_due;

  assign hit = (act_r == ActService) && cur_v && (cur_due != '0) && (cur_due <= now_r);
  assign once = (cur_step == '0);
  assign fin_ok  = cur_v && !(hit && once);
  assign fin_due = hit ? adv_due : cur_due;

  // RAM write port: item write on apply, advanced due on update.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {cur_tmr, cur_rep, adv_due};
    if (cmd.apply) begin
      ram_we    = wr_ok;
      ram_waddr = AW'(slot_r);
      ram_wdata = {tmr_r, rep_r, due_r};
    end else if (cmd.upd) begin
      ram_we = hit && !once;
    end
  end

  // Valid bits, scan index, earliest due and fired count.
  logic [TimeW-1:0] min_r;
  logic [4:0]       fcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.apply) begin
      if (act_r == ActClear) begin
        valid_r <= '0;
      end else if (wr_ok) begin
        valid_r[AW'(slot_r)] <= 1'b1;
      end
    end else if (cmd.upd && hit && once) begin
      valid_r[idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r  <= '0;
      min_r  <= '0;
      fcnt_r <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.upd && fin_ok && (fin_due != '0) &&
          ((min_r == '0) || (fin_due < min_r))) begin
        min_r <= fin_due;
      end
      if (cmd.emit_fire) begin
        fcnt_r <= fcnt_r + 1'b1;
      end
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_fire || cmd.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fire) begin
      out_kind           <= 1'b0;
      out_fired_slot     <= 4'(idx_r);
      out_fired_is_timer <= cur_tmr;
      out_fired_repeat   <= cur_rep;
      out_fired_due      <= cur_due;
      out_next_due       <= '0;
      out_fired_count    <= '0;
      out_last           <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_kind           <= 1'b1;
      out_fired_slot     <= '0;
      out_fired_is_timer <= 1'b0;
      out_fired_repeat   <= '0;
      out_fired_due      <= '0;
      out_next_due       <= min_r;
      out_fired_count    <= fcnt_r;
      out_last           <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller.
  assign sts.hit      = hit;
  assign sts.once     = once;
  assign sts.div_done = (dcnt_r == '0);
  assign sts.last_idx = (idx_r == AW'(SLOTS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> rtl/core/repeating_alarm_table_unit.sv
// Top level of the repeating alarm table: controller plus datapath.
// Depends on rat_pkg, rat_ctrl, rat_dp (and rat_ram below it).
//
// Usage: one item on the in_ channel is a clear, write or service action.
// The block takes one item at a time; in_stall is high from acceptance
// until the closing summary has been loaded into the output register.
// Every action scans all SLOTS slots in turn, each through a read, a
// check and an update state behind the slot RAM's registered read.
// On a service action each slot that fires adds a report and, for a
// daily or weekly slot, a reciprocal-multiply remainder pass that sets
// its next due time.
// Fired reports come out in ascending slot order, each with last low,
// followed by one summary with last high.
// The out_ channel holds one registered result; while out_stall is high
// the result holds and the scan waits before loading the next one.
// Reset (rst_n low, synchronous) empties every slot and drops out_valid.
`default_nettype none
module repeating_alarm_table_unit #(
  parameter int SLOTS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_action,
  input  wire logic [3:0]                in_slot,
  input  wire logic                      in_is_timer,
  input  wire logic [1:0]                in_repeat_mode,
  input  wire logic [rat_pkg::TimeW-1:0] in_due_time,
  input  wire logic [rat_pkg::TimeW-1:0] in_now_time,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_kind,
  output logic [3:0]                     out_fired_slot,
  output logic                           out_fired_is_timer,
  output logic [1:0]                     out_fired_repeat,
  output logic [rat_pkg::TimeW-1:0]      out_fired_due,
  output logic [rat_pkg::TimeW-1:0]      out_next_due,
  output logic [4:0]                     out_fired_count,
  output logic                           out_last
);
  import rat_pkg::*;

  rat_cmd_t    cmd;
  rat_status_t sts;

  // Sequencer.
  rat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  rat_dp #(.SLOTS(SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_slot            (in_slot),
    .in_is_timer        (in_is_timer),
    .in_repeat_mode     (in_repeat_mode),
    .in_due_time        (in_due_time),
    .in_now_time        (in_now_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_fired_slot     (out_fired_slot),
    .out_fired_is_timer (out_fired_is_timer),
    .out_fired_repeat   (out_fired_repeat),
    .out_fired_due      (out_fired_due),
    .out_next_due       (out_next_due),
    .out_fired_count    (out_fired_count),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire

>>> sim/tb_repeating_alarm_table_unit.sv
// Testbench for the repeating alarm table: directed and random actions
// checked against an in-bench model of the slot table.
// Depends on rat_pkg and repeating_alarm_table_unit.
`default_nettype none

// Outcome of one action as seen on the out_ channel.
typedef struct packed {
  logic                      kind;
  logic [3:0]                fired_slot;
  logic                      fired_is_timer;
  logic [1:0]                fired_repeat;
  logic [rat_pkg::TimeW-1:0] fired_due;
  logic [rat_pkg::TimeW-1:0] next_due;
  logic [4:0]                fired_count;
  logic                      last;
} alarm_report_t;

class alarm_table_scoreboard;
  bit                        slot_used [16];
  bit                        slot_timer [16];
  logic [1:0]                slot_rep [16];
  logic [rat_pkg::TimeW-1:0] slot_due [16];
  alarm_report_t             pending_reports [$];
  int                        error_count;

  function void wipe_slots();
    for (int i = 0; i < 16; i++) begin
      slot_used[i] = 0;
      slot_timer[i] = 0;
      slot_rep[i] = rat_pkg::RepOnce;
      slot_due[i] = '0;
    end
  endfunction

  // Predict the reports caused by one accepted action.
  function void note_action(logic [1:0] act, logic [3:0] idx, logic tmr,
                            logic [1:0] rep, logic [39:0] due, logic [39:0] now);
    alarm_report_t r;
    logic [63:0]   step;
    logic [63:0]   nd;
    logic [63:0]   best;
    logic [4:0]    fired;
    fired = '0;
    if (act == rat_pkg::ActClear) begin
      wipe_slots();
    end else if (act == rat_pkg::ActWrite) begin
      slot_used[idx] = 1;
      slot_timer[idx] = tmr;
      slot_rep[idx] = (rep == 2'd3) ? rat_pkg::RepOnce : rep;
      slot_due[idx] = due;
    end else if (act == rat_pkg::ActService) begin
      for (int i = 0; i < 16; i++) begin
        if (slot_used[i] && slot_due[i] != 0 && slot_due[i] <= now) begin
          r = '0;
          r.fired_slot = 4'(i);
          r.fired_is_timer = slot_timer[i];
          r.fired_repeat = slot_rep[i];
          r.fired_due = slot_due[i];
          pending_reports.push_back(r);
          fired++;
          step = (slot_rep[i] == rat_pkg::RepDaily) ? 64'd86400 :
                 (slot_rep[i] == rat_pkg::RepWeekly) ? 64'd604800 : 64'd0;
          if (step == 0) begin
            slot_used[i] = 0;
            slot_timer[i] = 0;
            slot_rep[i] = rat_pkg::RepOnce;
            slot_due[i] = '0;
          end else begin
            nd = 64'(slot_due[i]) + ((64'(now) - 64'(slot_due[i])) / step + 1) * step;
            slot_due[i] = (nd > 64'(rat_pkg::TimeMax)) ? rat_pkg::TimeMax : nd[39:0];
          end
        end
      end
    end
    best = 0;
    for (int i = 0; i < 16; i++)
      if (slot_used[i] && slot_due[i] != 0 && (best == 0 || 64'(slot_due[i]) < best))
        best = 64'(slot_due[i]);
    r = '0;
    r.kind = 1'b1;
    r.next_due = best[39:0];
    r.fired_count = fired;
    r.last = 1'b1;
    pending_reports.push_back(r);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Compare one accepted result with the oldest expectation.
  task check_report(alarm_report_t got);
    alarm_report_t w;
    if (pending_reports.size() == 0) begin
      report_mismatch("unexpected result", 64'(got.kind), 64'd0);
      return;
    end
    w = pending_reports.pop_front();
    if (got.kind !== w.kind) report_mismatch("kind", 64'(got.kind), 64'(w.kind));
    if (got.fired_slot !== w.fired_slot)
      report_mismatch("fired_slot", 64'(got.fired_slot), 64'(w.fired_slot));
    if (got.fired_is_timer !== w.fired_is_timer)
      report_mismatch("fired_is_timer", 64'(got.fired_is_timer), 64'(w.fired_is_timer));
    if (got.fired_repeat !== w.fired_repeat)
      report_mismatch("fired_repeat", 64'(got.fired_repeat), 64'(w.fired_repeat));
    if (got.fired_due !== w.fired_due)
      report_mismatch("fired_due", 64'(got.fired_due), 64'(w.fired_due));
    if (got.next_due !== w.next_due)
      report_mismatch("next_due", 64'(got.next_due), 64'(w.next_due));
    if (got.fired_count !== w.fired_count)
      report_mismatch("fired_count", 64'(got.fired_count), 64'(w.fired_count));
    if (got.last !== w.last) report_mismatch("last", 64'(got.last), 64'(w.last));
  endtask
endclass

module tb_repeating_alarm_table_unit;
  import rat_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_action;
  logic [3:0]        in_slot;
  logic              in_is_timer;
  logic [1:0]        in_repeat_mode;
  logic [TimeW-1:0]  in_due_time;
  logic [TimeW-1:0]  in_now_time;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [3:0]        out_fired_slot;
  logic              out_fired_is_timer;
  logic [1:0]        out_fired_repeat;
  logic [TimeW-1:0]  out_fired_due;
  logic [TimeW-1:0]  out_next_due;
  logic [4:0]        out_fired_count;
  logic              out_last;

  alarm_table_scoreboard alarm_sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  bit  hold_off_done;
  logic [TimeW-1:0] clock_now;

  repeating_alarm_table_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Generous bound on the whole run.
  initial begin
    #4000000;
    $display("tb_repeating_alarm_table_unit: done, errors");
    $finish;
  end

  // Sample accepted results at the rising edge.
  always @(posedge clk) begin
    alarm_report_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_fired_slot, out_fired_is_timer, out_fired_repeat,
              out_fired_due, out_next_due, out_fired_count, out_last};
      alarm_sb.check_report(got);
    end
  end

  // Receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    int n;
    out_stall = 0;
    hold_off_done = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_off_done) begin
        out_stall <= 1;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_off_done = 1;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one item and wait until it is accepted.
  task automatic send_action(logic [1:0] act, logic [3:0] idx, logic tmr,
                             logic [1:0] rep, logic [39:0] due, logic [39:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_slot <= idx;
    in_is_timer <= tmr;
    in_repeat_mode <= rep;
    in_due_time <= due;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alarm_sb.note_action(act, idx, tmr, rep, due, now);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(negedge clk);
  endtask

  // Random due time near the running clock, sometimes at the extremes.
  function automatic logic [39:0] pick_due();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return TimeMax - 40'($urandom_range(700000));
    if (sel == 2) return 40'({$urandom, $urandom});
    return clock_now + 40'($urandom_range(2000000)) - 40'd1000000;
  endfunction

  task automatic random_actions(int count);
    int pick;
    logic [39:0] nowv;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_action(ActClear, 4'($urandom), 1'($urandom), 2'($urandom),
                    40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
      end else if (pick < 5) begin
        send_action(2'd3, 4'($urandom), 1'($urandom), 2'($urandom),
                    40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
      end else if (pick < 55) begin
        send_action(ActWrite, 4'($urandom), 1'($urandom), 2'($urandom_range(3)),
                    pick_due(), 40'({$urandom, $urandom}));
      end else begin
        case ($urandom_range(9))
          0: nowv = TimeMax;
          1: nowv = 40'({$urandom, $urandom});
          default: begin
            clock_now = clock_now + 40'($urandom_range(900000));
            nowv = clock_now;
          end
        endcase
        send_action(ActService, 4'($urandom), 1'($urandom), 2'($urandom),
                    40'({$urandom, $urandom}), nowv);
      end
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (alarm_sb.pending_reports.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  initial begin
    alarm_sb = new();
    alarm_sb.wipe_slots();
    rst_n = 0;
    in_valid = 0;
    in_action = ActClear;
    in_slot = '0;
    in_is_timer = 0;
    in_repeat_mode = RepOnce;
    in_due_time = '0;
    in_now_time = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    clock_now = 40'd1700000000;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, every action, unknown action and repeat, saturation.
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, TimeMax);
    send_action(ActWrite, 4'd0, 1'b1, RepOnce, 40'd100, '0);
    send_action(ActWrite, 4'd15, 1'b0, RepDaily, 40'd200, '0);
    send_action(ActWrite, 4'd7, 1'b1, RepWeekly, 40'd300, '0);
    send_action(ActWrite, 4'd3, 1'b0, 2'd3, 40'd50, '0);
    send_action(ActWrite, 4'd4, 1'b1, RepDaily, 40'd0, '0);
    send_action(ActWrite, 4'd9, 1'b0, RepWeekly, TimeMax - 40'd5, '0);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, 40'd99);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, 40'd250);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, 40'd10000000);
    send_action(2'd3, 4'd15, 1'b1, 2'd3, TimeMax, TimeMax);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, TimeMax);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, TimeMax);
    for (int i = 0; i < 16; i++)
      send_action(ActWrite, 4'(i), i[0], 2'(i % 3), 40'd1 + 40'(i), '0);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, 40'd500000);
    send_action(ActClear, 4'hF, 1'b1, 2'd3, TimeMax, TimeMax);
    send_action(ActService, 4'd0, 1'b0, RepOnce, '0, TimeMax);

    // Random phases with different idling.
    random_actions(50);
    send_idle_pct = 52;
    random_actions(45);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    random_actions(45);
    // Long receiver hold-off while items keep coming.
    hold_off = 1;
    recv_stall_pct = 0;
    random_actions(20);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    random_actions(28);
    go_idle();

    drain();
    repeat (200) @(negedge clk);
    if (alarm_sb.error_count == 0 && alarm_sb.pending_reports.size() == 0)
      $display("tb_repeating_alarm_table_unit: done, clean");
    else
      $display("tb_repeating_alarm_table_unit: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
